@@ design/deadline_poll_scheduler_macros.svh @@
// assertion helpers for the deadline poll scheduler
`ifndef DEADLINE_POLL_SCHEDULER_MACROS_SVH
`define DEADLINE_POLL_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define DPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define DPS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define DPS_ASSERT(label, prop, msg)

`define DPS_ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ design/dps_pkg.sv @@
`default_nettype none

package dps_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_CHECK,
        ST_FIRE,
        ST_BUBBLE
    } dps_state_t;

    // timers that own configuration registers
    localparam int REG_TIMERS = 4;
    localparam int REG_IDX_W = 2;

    // apb register file
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_ADDR_LSB = 2;

    localparam int COUNT_W = 8;
    localparam int PERIOD_W = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd1;

    // firing limit per input beat
    localparam int FIRE_CNT_W = 3;
    localparam logic [FIRE_CNT_W-1:0] MAX_FIRINGS = 3'd4;

    // result field widths
    localparam int OUT_ID_W = 2;
    localparam int OUT_ITEM_W = 8;

endpackage

`default_nettype wire

@@ design/deadline_poll_scheduler.sv @@
// deadline poll scheduler: up to four firings per input beat, one result beat per firing
// per beat: a clock advance when tick is set, then head checks; each firing adds a deadline
//   update and queue bubbling, all through one shared time adder
// input: a new beat is taken only in idle, once the last one is done; output stalls hold it
// reset: synchronous active-low aresetn clears clock, indices, counts; periods to 1000,
//   deadlines to START_DELAY, queue to timer order; no clearing pass
`default_nettype none

`include "deadline_poll_scheduler_macros.svh"

module deadline_poll_scheduler #(
    parameter int TIMER_SLOTS = 4,
    parameter int TIME_WIDTH  = 32,
    parameter int START_DELAY = 97,
    parameter int ITEM_WIDTH  = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_tick,
    input  wire logic                              s_diag_mode,

    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [dps_pkg::OUT_ID_W-1:0]           m_timer_id,
    output logic [dps_pkg::OUT_ITEM_W-1:0]         m_item_number,
    output logic                                   m_poll_allowed,
    output logic                                   m_last_of_tick,

    // apb configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dps_pkg::APB_AW-1:0]        paddr,
    input  wire logic [dps_pkg::APB_DW-1:0]        pwdata,
    output logic [dps_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);

    // timer number and queue position width
    localparam int TIDW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    // common width for comparing an index against a count
    localparam int CMP_W = ITEM_WIDTH + 9;
    // count bits that survive the item width
    localparam logic [dps_pkg::COUNT_W-1:0] CNT_MASK =
        (ITEM_WIDTH >= dps_pkg::COUNT_W) ? {dps_pkg::COUNT_W{1'b1}} :
        dps_pkg::COUNT_W'((1 << ITEM_WIDTH) - 1);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    dps_pkg::dps_state_t state_reg, state_next;

    logic [TIME_WIDTH-1:0]          clock_reg;
    logic [TIME_WIDTH-1:0]          dl_reg [TIMER_SLOTS];
    logic [ITEM_WIDTH-1:0]          idx_reg [TIMER_SLOTS];
    logic [TIDW-1:0]                q_reg [TIMER_SLOTS];

    logic [dps_pkg::COUNT_W-1:0]    count_reg [dps_pkg::REG_TIMERS];
    logic [dps_pkg::PERIOD_W-1:0]   period_reg [dps_pkg::REG_TIMERS];

    // per-beat working registers
    logic [dps_pkg::FIRE_CNT_W-1:0] fire_cnt_reg;
    logic                           allowed_reg;
    logic [TIDW-1:0]                fire_t_reg;
    logic [TIME_WIDTH-1:0]          fire_dl_reg;
    logic [TIDW-1:0]                bub_pos_reg;

    // pending result, held until we know whether another firing follows
    logic [dps_pkg::OUT_ID_W-1:0]   pend_timer_reg;
    logic [dps_pkg::OUT_ITEM_W-1:0] pend_item_reg;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [dps_pkg::OUT_ID_W-1:0]   m_timer_id_reg;
    logic [dps_pkg::OUT_ITEM_W-1:0] m_item_number_reg;
    logic                           m_poll_allowed_reg;
    logic                           m_last_of_tick_reg;

    // ------------------------------------------------------------------
    // queue view: enable per position, head search, single read port
    // ------------------------------------------------------------------
    logic [TIMER_SLOTS-1:0] en_pos;
    logic                   head_found;
    logic [TIDW-1:0]        head_pos;
    logic                   bub_at_end;
    logic [TIDW-1:0]        q_rd_pos;
    logic [TIDW-1:0]        q_rd;
    logic                   en_rd;

    always_comb begin
        logic [TIDW-1:0] tq;
        for (int k = 0; k < TIMER_SLOTS; k++) begin
            tq = q_reg[k];
            // timers past the register file have no count and stay off
            en_pos[k] = (int'(tq) < dps_pkg::REG_TIMERS) &&
                        ((count_reg[dps_pkg::REG_IDX_W'(tq)] & CNT_MASK) != '0);
        end
    end

    // first enabled queue entry is the head
    always_comb begin
        head_found = 1'b0;
        head_pos   = '0;
        for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
            if (en_pos[k]) begin
                head_found = 1'b1;
                head_pos   = TIDW'(k);
            end
        end
    end

    assign bub_at_end = (int'(bub_pos_reg) == TIMER_SLOTS - 1);

    // check reads the head, bubbling reads the entry just behind the mover
    always_comb begin
        if (state_reg == dps_pkg::ST_CHECK) begin
            q_rd_pos = head_pos;
        end else if (bub_at_end) begin
            q_rd_pos = bub_pos_reg;
        end else begin
            q_rd_pos = TIDW'(bub_pos_reg + 1'b1);
        end
    end

    assign q_rd  = q_reg[q_rd_pos];
    assign en_rd = en_pos[q_rd_pos];

    // ------------------------------------------------------------------
    // shared time adder and wrap-aware compare
    // ------------------------------------------------------------------
    logic [TIME_WIDTH-1:0]        unit_a, unit_b, unit_res;
    logic                         unit_sub;
    logic                         b_earlier;
    logic [TIDW-1:0]              dl_rd_idx;
    logic [TIME_WIDTH-1:0]        dl_rd;
    logic [dps_pkg::PERIOD_W-1:0] per_raw, per_eff;

    assign dl_rd     = dl_reg[dl_rd_idx];
    assign unit_res  = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);
    // a - b nonzero and positive: b lies strictly before a
    assign b_earlier = (unit_res != '0) && !unit_res[TIME_WIDTH-1];

    // zero period runs as one millisecond
    assign per_raw = period_reg[dps_pkg::REG_IDX_W'(fire_t_reg)];
    assign per_eff = (per_raw == '0) ? dps_pkg::PERIOD_MIN : per_raw;

    // ------------------------------------------------------------------
    // item index advance
    // ------------------------------------------------------------------
    logic [ITEM_WIDTH:0]          idx_inc, idx_new;
    logic [dps_pkg::COUNT_W-1:0]  fire_cnt_masked;

    assign fire_cnt_masked = count_reg[dps_pkg::REG_IDX_W'(fire_t_reg)] & CNT_MASK;
    assign idx_inc = {1'b0, idx_reg[fire_t_reg]} + {{ITEM_WIDTH{1'b0}}, 1'b1};
    // wrap to one past the count, also when the count was lowered
    assign idx_new = (CMP_W'(idx_inc) > CMP_W'(fire_cnt_masked)) ?
                     {{ITEM_WIDTH{1'b0}}, 1'b1} : idx_inc;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic pend;
    logic fire_ok;
    logic bub_stop;
    logic push;
    logic push_last;

    assign out_free = !m_valid_reg || m_ready;
    assign pend     = (fire_cnt_reg != '0);
    assign fire_ok  = head_found && !b_earlier && (fire_cnt_reg < dps_pkg::MAX_FIRINGS);
    // mover stops in front of an enabled entry with a later deadline
    assign bub_stop = bub_at_end || (en_rd && b_earlier);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_tick ? dps_pkg::ST_INC : dps_pkg::ST_CHECK;
                end
            end
            dps_pkg::ST_INC: begin
                state_next = dps_pkg::ST_CHECK;
            end
            dps_pkg::ST_CHECK: begin
                // wait while a pending beat has nowhere to go
                if (!pend || out_free) begin
                    state_next = fire_ok ? dps_pkg::ST_FIRE : dps_pkg::ST_IDLE;
                end
            end
            dps_pkg::ST_FIRE: begin
                state_next = dps_pkg::ST_BUBBLE;
            end
            dps_pkg::ST_BUBBLE: begin
                if (bub_stop) begin
                    state_next = dps_pkg::ST_CHECK;
                end
            end
            default: begin
                state_next = dps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        unit_a    = dl_rd;
        unit_b    = clock_reg;
        unit_sub  = 1'b1;
        dl_rd_idx = q_rd;
        push      = 1'b0;
        push_last = 1'b0;
        unique case (state_reg)
            dps_pkg::ST_IDLE: begin
            end
            dps_pkg::ST_INC: begin
                // clock advance
                unit_a   = clock_reg;
                unit_b   = {{(TIME_WIDTH-1){1'b0}}, 1'b1};
                unit_sub = 1'b0;
            end
            dps_pkg::ST_CHECK: begin
                // head deadline against the clock
                push      = pend && out_free;
                push_last = !fire_ok;
            end
            dps_pkg::ST_FIRE: begin
                // deadline plus period
                dl_rd_idx = fire_t_reg;
                unit_b    = TIME_WIDTH'(per_eff);
                unit_sub  = 1'b0;
            end
            dps_pkg::ST_BUBBLE: begin
                // next entry deadline against the mover
                unit_b = fire_dl_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [dps_pkg::APB_AW-dps_pkg::REG_ADDR_LSB-1:0] cfg_idx;
    logic [dps_pkg::REG_IDX_W-1:0]                    cfg_slot;
    logic                                             cfg_is_count;
    logic                                             cfg_wr;

    assign cfg_idx      = paddr[dps_pkg::APB_AW-1:dps_pkg::REG_ADDR_LSB];
    assign cfg_slot     = cfg_idx[dps_pkg::REG_IDX_W-1:0];
    assign cfg_is_count = (int'(cfg_idx) < dps_pkg::REG_TIMERS);
    assign cfg_wr       = psel && penable && pwrite;
    assign pready       = 1'b1;

    assign prdata = cfg_is_count ? dps_pkg::APB_DW'(count_reg[cfg_slot]) :
                                   dps_pkg::APB_DW'(period_reg[cfg_slot]);

    // ------------------------------------------------------------------
    // registers with reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dps_pkg::ST_IDLE;
            clock_reg    <= '0;
            fire_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < TIMER_SLOTS; k++) begin
                dl_reg[k]  <= TIME_WIDTH'(START_DELAY);
                idx_reg[k] <= '0;
                q_reg[k]   <= TIDW'(k);
            end
            for (int k = 0; k < dps_pkg::REG_TIMERS; k++) begin
                count_reg[k]  <= '0;
                period_reg[k] <= dps_pkg::PERIOD_RESET;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;

            // writes to timers that do not exist are dropped
            if (cfg_wr && (int'(cfg_slot) < TIMER_SLOTS)) begin
                if (cfg_is_count) begin
                    count_reg[cfg_slot] <= pwdata[dps_pkg::COUNT_W-1:0];
                end else begin
                    period_reg[cfg_slot] <= pwdata[dps_pkg::PERIOD_W-1:0];
                end
            end

            if (state_reg == dps_pkg::ST_IDLE && s_valid) begin
                fire_cnt_reg <= '0;
            end
            if (state_reg == dps_pkg::ST_INC) begin
                clock_reg <= unit_res;
            end
            if (state_reg == dps_pkg::ST_FIRE) begin
                dl_reg[fire_t_reg]  <= unit_res;
                idx_reg[fire_t_reg] <= ITEM_WIDTH'(idx_new);
                fire_cnt_reg        <= fire_cnt_reg + 1'b1;
            end
            // swap mover one place back; the mover always sits at bub_pos
            if (state_reg == dps_pkg::ST_BUBBLE && !bub_stop) begin
                q_reg[bub_pos_reg] <= q_rd;
                q_reg[q_rd_pos]    <= fire_t_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == dps_pkg::ST_IDLE && s_valid) begin
            allowed_reg <= !s_diag_mode;
        end
        if (state_reg == dps_pkg::ST_CHECK && state_next == dps_pkg::ST_FIRE) begin
            fire_t_reg  <= q_rd;
            bub_pos_reg <= head_pos;
        end
        if (state_reg == dps_pkg::ST_FIRE) begin
            fire_dl_reg    <= unit_res;
            pend_timer_reg <= dps_pkg::OUT_ID_W'(fire_t_reg);
            pend_item_reg  <= dps_pkg::OUT_ITEM_W'(idx_new);
        end
        if (state_reg == dps_pkg::ST_BUBBLE && !bub_stop) begin
            bub_pos_reg <= q_rd_pos;
        end
        if (push) begin
            m_timer_id_reg     <= pend_timer_reg;
            m_item_number_reg  <= pend_item_reg;
            m_poll_allowed_reg <= allowed_reg;
            m_last_of_tick_reg <= push_last;
        end
    end

    assign s_ready        = (state_reg == dps_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_timer_id     = m_timer_id_reg;
    assign m_item_number  = m_item_number_reg;
    assign m_poll_allowed = m_poll_allowed_reg;
    assign m_last_of_tick = m_last_of_tick_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DPS_ASSERT_NEVER(a_no_overwrite, push && m_valid_reg && !m_ready, "result beat overwritten")
    `DPS_ASSERT(a_fire_limit, (state_reg == dps_pkg::ST_CHECK && state_next == dps_pkg::ST_FIRE) |-> (head_found && fire_cnt_reg < dps_pkg::MAX_FIRINGS), "firing without head or past limit")
    `DPS_ASSERT(a_last_marked, (state_reg == dps_pkg::ST_CHECK && state_next == dps_pkg::ST_IDLE && pend) |=> (m_valid_reg && m_last_of_tick_reg), "final beat of an input not marked last")
    `DPS_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready, "second beat taken while busy")

endmodule

`default_nettype wire

@@ dv/deadline_poll_scheduler_tb.sv @@
module deadline_poll_scheduler_tb;

    localparam int NT       = 4;
    localparam int TIME_W   = 32;
    localparam int ORD_W    = $clog2(NT);
    localparam int ADDR_W   = dps_pkg::APB_AW;
    localparam int DATA_W   = dps_pkg::APB_DW;
    localparam int ID_W     = dps_pkg::OUT_ID_W;
    localparam int ITEM_W   = dps_pkg::OUT_ITEM_W;
    localparam int CNT_W    = dps_pkg::COUNT_W;
    localparam int PER_W    = dps_pkg::PERIOD_W;

    // settle slack that covers a beat still in flight after its last firing has left
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 14;
    localparam int RANDOM_BEATS  = 24;
    localparam int PHASE_BEATS   = 6;
    localparam int MAX_PHASES    = 5;
    localparam int START_DUE     = 97;

    // register map, one 32-bit word per register
    localparam int R_COUNT_A  = 0;
    localparam int R_COUNT_B  = 1;
    localparam int R_COUNT_C  = 2;
    localparam int R_COUNT_D  = 3;
    localparam int R_PERIOD_A = 4;
    localparam int R_PERIOD_B = 5;
    localparam int R_PERIOD_C = 6;
    localparam int R_PERIOD_D = 7;
    localparam int NUM_REGS   = 8;

    // row marker: firings come from the schedule model, not from the row
    localparam int PREDICTED = -1;

    typedef enum {ROW_BEAT, ROW_WRITE, ROW_READ} row_kind_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ITEM_W-1:0] item;
        logic              allowed;
        logic              last;
    } firing_t;

    typedef struct {
        row_kind_t         kind;
        int                reps;
        logic              tk;
        logic              dg;
        int                n_fix;
        logic [ID_W-1:0]   id;
        logic [ITEM_W-1:0] item;
        int                regi;
        logic [DATA_W-1:0] val;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_tick = 1'b0;
    logic              s_diag_mode = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ID_W-1:0]   m_timer_id;
    logic [ITEM_W-1:0] m_item_number;
    logic              m_poll_allowed;
    logic              m_last_of_tick;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    deadline_poll_scheduler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tick        (s_tick),
        .s_diag_mode   (s_diag_mode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_timer_id    (m_timer_id),
        .m_item_number (m_item_number),
        .m_poll_allowed(m_poll_allowed),
        .m_last_of_tick(m_last_of_tick),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // schedule model: its own copy of the clock, the deadline queue and
    // the registers, stepped once per accepted input beat
    // ---------------------------------------------------------------
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] deadline [NT];
    logic [ITEM_W-1:0] item_idx [NT];
    logic [ORD_W-1:0]  queue_ord [NT];
    logic [CNT_W-1:0]  count_cfg [NT];
    logic [PER_W-1:0]  period_cfg [NT];

    firing_t   fired_now[$];       // firings of the beat just modeled
    firing_t   pending_fires[$];   // firings still owed by the block, oldest first
    stim_row_t dir_rows[$];
    firing_t   want;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit beat_since_settle = 1'b0;
    int fail_count = 0;
    int beats_sent = 0;
    int fires_checked = 0;
    int reg_writes = 0;
    int max_burst = 0;
    int rand_beats = 0;
    int rand_fires = 0;
    int phase = 0;

    function automatic void reset_schedule();
        now_ms = '0;
        for (int i = 0; i < NT; i++) begin
            deadline[i]   = TIME_W'(START_DUE);
            item_idx[i]   = '0;
            queue_ord[i]  = ORD_W'(i);
            count_cfg[i]  = '0;
            period_cfg[i] = dps_pkg::PERIOD_RESET;
        end
    endfunction

    // strictly earlier, by wrap-aware difference
    function automatic bit is_earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = b - a;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    function automatic void advance_schedule(input logic tk, input logic dg);
        int               p;
        int               nxt;
        logic [ORD_W-1:0] t;
        logic [ORD_W-1:0] o;
        logic [PER_W-1:0] step;
        firing_t          f;
        fired_now.delete();
        if (tk) now_ms = now_ms + 1'b1;
        while (fired_now.size() < int'(dps_pkg::MAX_FIRINGS)) begin
            // head is the first enabled entry of the queue
            p = 0;
            while (p < NT && count_cfg[queue_ord[p]] == '0) p++;
            if (p >= NT) break;
            t = queue_ord[p];
            if (is_earlier(now_ms, deadline[t])) break;
            // round robin index, also wraps when above a lowered count
            nxt = int'(item_idx[t]) + 1;
            if (nxt > int'(count_cfg[t])) nxt = 1;
            item_idx[t] = ITEM_W'(nxt);
            // a zero period behaves as one
            step = (period_cfg[t] == '0) ? dps_pkg::PERIOD_MIN : period_cfg[t];
            deadline[t] = deadline[t] + TIME_W'(step);
            // bubble back past disabled entries and equal or earlier deadlines
            for (int k = p; k + 1 < NT; k++) begin
                o = queue_ord[k + 1];
                if (count_cfg[o] != '0 && is_earlier(deadline[t], deadline[o])) break;
                queue_ord[k + 1] = queue_ord[k];
                queue_ord[k]     = o;
            end
            f.id      = ID_W'(t);
            f.item    = item_idx[t];
            f.allowed = !dg;
            f.last    = 1'b0;
            fired_now.push_back(f);
        end
        if (fired_now.size() > 0) fired_now[fired_now.size() - 1].last = 1'b1;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // ---------------------------------------------------------------
    // directed table builders
    // ---------------------------------------------------------------
    function automatic void add_beats(input int reps, input logic tk, input logic dg,
                                      input int n_fix, input logic [ID_W-1:0] id,
                                      input logic [ITEM_W-1:0] item);
        stim_row_t r;
        r = '{kind: ROW_BEAT, reps: reps, tk: tk, dg: dg, n_fix: n_fix, id: id,
              item: item, regi: 0, val: '0};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_reg(input row_kind_t kind, input int regi,
                                    input logic [DATA_W-1:0] val);
        stim_row_t r;
        r = '{kind: kind, reps: 0, tk: 1'b0, dg: 1'b0, n_fix: 0, id: '0, item: '0,
              regi: regi, val: val};
        dir_rows.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    task automatic send_beat(input logic tk, input logic dg, input int n_fix,
                             input logic [ID_W-1:0] fix_id, input logic [ITEM_W-1:0] fix_item);
        int      gap;
        firing_t f;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_tick      <= tk;
        s_diag_mode <= dg;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // beat accepted at this edge: step the model, queue what it owes
        advance_schedule(tk, dg);
        if (n_fix == PREDICTED) begin
            foreach (fired_now[i]) pending_fires.push_back(fired_now[i]);
        end else if (n_fix > 0) begin
            f = '{id: fix_id, item: fix_item, allowed: !dg, last: 1'b1};
            pending_fires.push_back(f);
        end
        beats_sent++;
        if (fired_now.size() > max_burst) max_burst = fired_now.size();
        beat_since_settle = 1'b1;
    endtask

    // sender holds off until every owed firing is out, plus some slack
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_fires.size() != 0);
        repeat (extra) @(posedge aclk);
        beat_since_settle = 1'b0;
    endtask

    task automatic apb_write(input int regi, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(regi << dps_pkg::REG_ADDR_LSB);
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (regi < R_PERIOD_A) count_cfg[regi] = v[CNT_W-1:0];
        else period_cfg[regi - R_PERIOD_A] = v[PER_W-1:0];
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic apb_read(input int regi, output logic [DATA_W-1:0] got);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(regi << dps_pkg::REG_ADDR_LSB);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input int regi, input logic [DATA_W-1:0] exp_val);
        logic [DATA_W-1:0] got;
        apb_read(regi, got);
        if (got !== exp_val)
            note_failure($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                   regi, got, exp_val));
    endtask

    // mostly small counts so the round robin wraps often, plus 0 and 255
    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0: return '0;
            1: return '1;
            default: return CNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    // mostly short periods so firings are frequent, plus 0, 65535 and anything
    function automatic logic [PER_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0: return '0;
            1: return '1;
            2: return PER_W'($urandom_range(1, 65535));
            default: return PER_W'($urandom_range(1, 8));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result sink: random stall before each beat, none in quiet phases
    // ---------------------------------------------------------------
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // every result beat is held against the oldest owed firing
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_fires.size() == 0) begin
                note_failure($sformatf("unexpected firing: timer %0d item %0d poll %0b last %0b",
                                       m_timer_id, m_item_number, m_poll_allowed,
                                       m_last_of_tick));
            end else begin
                want = pending_fires.pop_front();
                fires_checked++;
                if (m_timer_id !== want.id || m_item_number !== want.item ||
                    m_poll_allowed !== want.allowed || m_last_of_tick !== want.last)
                    note_failure($sformatf({"firing %0d: expected timer %0d item %0d ",
                                            "poll %0b last %0b, got %0d %0d %0b %0b"},
                                           fires_checked, want.id, want.item, want.allowed,
                                           want.last, m_timer_id, m_item_number,
                                           m_poll_allowed, m_last_of_tick));
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [DATA_W-1:0] v;
        int                regi;
        reset_schedule();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset: counts 0, periods 1000, every timer disabled
        for (int i = 0; i < NT; i++) add_reg(ROW_READ, R_COUNT_A + i, '0);
        for (int i = 0; i < NT; i++)
            add_reg(ROW_READ, R_PERIOD_A + i, DATA_W'(dps_pkg::PERIOD_RESET));
        add_beats(2, 1'b1, 1'b0, 0, '0, '0);
        add_beats(1, 1'b0, 1'b1, 0, '0, '0);
        // timer 0 with 3 items and a zero period, which acts as 1 ms
        add_reg(ROW_WRITE, R_COUNT_A, 32'd3);
        add_reg(ROW_WRITE, R_PERIOD_A, 32'd0);
        // walk the clock up to one short of the first deadline
        add_beats(START_DUE - 3, 1'b1, 1'b0, 0, '0, '0);
        add_beats(1, 1'b1, 1'b0, 1, 2'd0, 8'd1);
        add_beats(1, 1'b1, 1'b1, 1, 2'd0, 8'd2);   // diag: poll suppressed
        add_beats(1, 1'b0, 1'b0, 0, '0, '0);       // recheck only, nothing due
        add_beats(1, 1'b1, 1'b0, 1, 2'd0, 8'd3);
        add_beats(1, 1'b1, 1'b0, 1, 2'd0, 8'd1);   // index wraps past the count
        add_reg(ROW_READ, R_COUNT_A, 32'd3);
        // late enable of timer 1: old deadline far behind, backlog capped at four
        add_reg(ROW_WRITE, R_PERIOD_B, 32'd1);
        add_reg(ROW_WRITE, R_COUNT_B, 32'd255);
        add_beats(1, 1'b0, 1'b0, PREDICTED, '0, '0);
        add_beats(1, 1'b1, 1'b1, PREDICTED, '0, '0);
        // longest periods, widest count
        add_reg(ROW_WRITE, R_COUNT_C, 32'd1);
        add_reg(ROW_WRITE, R_PERIOD_C, 32'd65535);
        add_reg(ROW_WRITE, R_COUNT_D, 32'd255);
        add_reg(ROW_WRITE, R_PERIOD_D, 32'd65535);
        add_reg(ROW_READ, R_COUNT_D, 32'd255);
        add_reg(ROW_READ, R_PERIOD_C, 32'd65535);
        add_beats(3, 1'b1, 1'b0, PREDICTED, '0, '0);
        // count lowered below the running index of timer 1
        add_reg(ROW_WRITE, R_COUNT_B, 32'd2);
        add_beats(3, 1'b1, 1'b0, PREDICTED, '0, '0);
        // disable timer 0 again
        add_reg(ROW_WRITE, R_COUNT_A, 32'd0);
        add_beats(1, 1'b1, 1'b1, PREDICTED, '0, '0);
        add_beats(1, 1'b0, 1'b0, PREDICTED, '0, '0);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_BEAT: begin
                    repeat (dir_rows[i].reps)
                        send_beat(dir_rows[i].tk, dir_rows[i].dg, dir_rows[i].n_fix,
                                  dir_rows[i].id, dir_rows[i].item);
                end
                ROW_WRITE: begin
                    if (beat_since_settle) settle(SETTLE_CYCLES);
                    apb_write(dir_rows[i].regi, dir_rows[i].val);
                end
                default: begin
                    if (beat_since_settle) settle(SETTLE_CYCLES);
                    check_reg(dir_rows[i].regi, dir_rows[i].val);
                end
            endcase
        end

        // random phases, each with a fresh register setting
        while (rand_beats < RANDOM_BEATS && phase < MAX_PHASES) begin
            if (beat_since_settle) settle(SETTLE_CYCLES);
            // some phases run with no idling on one or both sides
            tx_idle = (phase % 3) != 2;
            rx_idle = (phase % 4) != 1;
            for (int t = 0; t < NT; t++) begin
                v = $urandom();
                v[CNT_W-1:0] = (phase == 0) ? '1 : pick_count();
                apb_write(R_COUNT_A + t, v);
                v = $urandom();
                v[PER_W-1:0] = (phase == 0) ? PER_W'(1) : pick_period();
                apb_write(R_PERIOD_A + t, v);
            end
            // read one register back
            regi = $urandom_range(0, NUM_REGS - 1);
            if (regi < R_PERIOD_A)
                check_reg(regi, DATA_W'(count_cfg[regi]));
            else
                check_reg(regi, DATA_W'(period_cfg[regi - R_PERIOD_A]));
            repeat (PHASE_BEATS) begin
                if ($urandom_range(0, 19) == 0) settle(0);
                send_beat($urandom_range(0, 9) < 8, 1'($urandom_range(0, 1)), PREDICTED,
                          '0, '0);
                rand_beats++;
                rand_fires += fired_now.size();
            end
            phase++;
        end

        settle(SETTLE_CYCLES);
        $display("covered %0d input beats (%0d random, %0d random firings), %0d firings checked",
                 beats_sent, rand_beats, rand_fires, fires_checked);
        $display("up to %0d firings per beat; %0d register writes over %0d random settings",
                 max_burst, reg_writes, phase);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #3000000;
        $display("timeout with %0d firings still owed", pending_fires.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
